@@ rtl/dne_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dne_pkg: shared types and constants of the Delannoy number engine
// Word widths, sequencer state codes and the control word sent to the cells.
// ----------------------------------------------------------------------------
package dne_pkg;

  localparam int unsigned FIELD_W = 6;   // width of each grid coordinate
  localparam int unsigned VALUE_W = 64;  // width of a count, wraps mod 2^64

  localparam logic [VALUE_W-1:0] ONE = VALUE_W'(1);

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CALC  = 3'b010,
    S_SHIFT = 3'b100
  } dne_state_e;

  // Control word broadcast from the sequencer to every cell
  typedef struct packed {
    logic init;   // load row 0 (all ones) and clear the enable chain
    logic shift;  // move every value one cell towards the end of the chain
  } cell_ctl_t;

endpackage : dne_pkg
`default_nettype wire

@@ rtl/delannoy_number_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// delannoy_number_engine: Delannoy number D(x,y) modulo 2^64
// A systolic row of cells builds the table row by row, then drains the answer.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | word
//  --------+--------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o  | row_index_i (x), col_index_i (y)
//  out     | out_valid_o / out_stall_i| count_value_o = D(x,y) mod 2^64
//
// Sequence: accept, the wavefront steps, the drain steps, one load into the
//   result register.
//   The time per word is set by the skewed wavefront through the cell row and the
//   drain of the answer along the same row to its last cell.
// Reset: rst_ni clears the sequencer, the enable chain and the result valid.
// Stalls: in_stall_o is high from acceptance until the result is loaded; the
//   result register lets the next word in while an answer still waits.
// ----------------------------------------------------------------------------
module delannoy_number_engine #(
  parameter int unsigned MAX_INDEX = 63
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [dne_pkg::FIELD_W-1:0]      row_index_i,
  input  wire  [dne_pkg::FIELD_W-1:0]      col_index_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [dne_pkg::VALUE_W-1:0]      count_value_o
);
  import dne_pkg::*;

  // Column 0 is the fixed border D(i,0) = 1; cells 1..MAX_INDEX follow it.
  cell_ctl_t          cell_ctl;
  logic               en_first;
  logic               en    [0:MAX_INDEX];
  logic [VALUE_W-1:0] val   [0:MAX_INDEX];
  logic [VALUE_W-1:0] prev  [0:MAX_INDEX];

  assign en[0]   = en_first;
  assign val[0]  = ONE;
  assign prev[0] = ONE;

  // Sequencer: clamp, time the wavefront, drain, hold the answer
  dne_ctrl #(
    .MAX_INDEX (MAX_INDEX)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .cell_ctl_o    (cell_ctl),
    .en_first_o    (en_first),
    .last_val_i    (val[MAX_INDEX]),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .count_value_o (count_value_o)
  );

  // Row of cells: each takes its left neighbour's current and previous value
  // and takes the enable token in the cycle after its neighbour, so row i
  // reaches column j at wavefront step i + j - 2.
  for (genvar j = 1; j <= MAX_INDEX; j++) begin : g_cell
    dne_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl),
      .en_i        (en[j-1]),
      .left_val_i  (val[j-1]),
      .left_prev_i (prev[j-1]),
      .en_o        (en[j]),
      .val_o       (val[j]),
      .prev_o      (prev[j])
    );
  end

endmodule : delannoy_number_engine
`default_nettype wire

@@ rtl/dne_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dne_cell: one column of the working row
// Holds D(i,j) and D(i-1,j); updates from its left neighbour when enabled or shifting.
// ----------------------------------------------------------------------------
module dne_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  dne_pkg::cell_ctl_t               ctl_i,
  input  wire                              en_i,
  input  wire  [dne_pkg::VALUE_W-1:0]      left_val_i,
  input  wire  [dne_pkg::VALUE_W-1:0]      left_prev_i,
  output logic                             en_o,
  output logic [dne_pkg::VALUE_W-1:0]      val_o,
  output logic [dne_pkg::VALUE_W-1:0]      prev_o
);
  import dne_pkg::*;

  logic               en_q;
  logic [VALUE_W-1:0] val_q;
  logic [VALUE_W-1:0] prev_q;

  // Enable token: pass it on through a register to skew the wavefront
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else begin
      en_q <= ctl_i.init ? 1'b0 : en_i;
    end
  end

  // up + left + diagonal, wrapping
  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      val_q  <= ONE;
      prev_q <= ONE;
    end else if (ctl_i.shift) begin
      val_q  <= left_val_i;
    end else if (en_i) begin
      val_q  <= val_q + left_val_i + left_prev_i;
      prev_q <= val_q;
    end
  end

  assign en_o   = en_q;
  assign val_o  = val_q;
  assign prev_o = prev_q;

endmodule : dne_cell
`default_nettype wire

@@ rtl/dne_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dne_ctrl: query sequencer and result register
// Clamps the coordinates, times the wavefront and the drain, holds the result.
// ----------------------------------------------------------------------------
module dne_ctrl #(
  parameter int unsigned MAX_INDEX = 63
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [dne_pkg::FIELD_W-1:0]      row_index_i,
  input  wire  [dne_pkg::FIELD_W-1:0]      col_index_i,
  output dne_pkg::cell_ctl_t               cell_ctl_o,
  output logic                             en_first_o,
  input  wire  [dne_pkg::VALUE_W-1:0]      last_val_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [dne_pkg::VALUE_W-1:0]      count_value_o
);
  import dne_pkg::*;

  localparam int unsigned IDX_W = (MAX_INDEX > 1) ? $clog2(MAX_INDEX + 1) : 1;
  localparam int unsigned CNT_W = $clog2(2 * MAX_INDEX + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_INDEX);

  dne_state_e         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   x_q, x_d, y_q, y_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_q;
  logic               accept, out_free, out_load;
  logic [CNT_W-1:0]   x_ext, y_ext, sum_xy;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign x_ext    = CNT_W'(x_q);
  assign y_ext    = CNT_W'(y_q);
  assign sum_xy   = x_ext + y_ext;
  assign out_load = (state_q == S_SHIFT) && (cnt_q == CNT_LAST) && out_free;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    y_d     = y_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          // saturate coordinates above the top index
          x_d     = (32'(row_index_i) > 32'(MAX_INDEX)) ? IDX_W'(MAX_INDEX)
                                                        : IDX_W'(row_index_i);
          y_d     = (32'(col_index_i) > 32'(MAX_INDEX)) ? IDX_W'(MAX_INDEX)
                                                        : IDX_W'(col_index_i);
          cnt_d   = '0;
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        if (cnt_q == sum_xy) begin
          cnt_d   = y_ext;
          state_d = S_SHIFT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_SHIFT: begin
        if (cnt_q != CNT_LAST) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    if (out_load) begin
      out_q <= last_val_i;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign cell_ctl_o.init  = accept;
  assign cell_ctl_o.shift = (state_q == S_SHIFT) && (cnt_q != CNT_LAST);
  assign en_first_o       = (state_q == S_CALC) && (cnt_q < x_ext);
  assign out_valid_o      = out_valid_q;
  assign count_value_o    = out_q;

  a_accept_starts_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CALC) && (cnt_q == '0))
    else $error("accepted word did not start the wavefront");

  a_no_shift_while_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctl_o.shift |-> !en_first_o && !cell_ctl_o.init)
    else $error("drain overlaps wavefront injection");

  a_calc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |-> (cnt_q <= sum_xy))
    else $error("wavefront counter overran");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (state_q == S_IDLE))
    else $error("result load lost");

endmodule : dne_ctrl
`default_nettype wire
